// ===== hw/rtl/tav_pkg.sv =====
package tav_pkg;

  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned TRIG_SHIFT = 14;

  localparam logic [8:0] DEG_QUARTER = 9'd90;
  localparam logic [8:0] DEG_HALF    = 9'd180;
  localparam logic [8:0] DEG_THREEQ  = 9'd270;
  localparam logic [8:0] DEG_TURN    = 9'd360;
  localparam logic [8:0] AVOID_OFFSET_DEG = 9'd60;

  typedef enum logic [2:0] {
    CFG_TARGET_EAST,
    CFG_TARGET_NORTH,
    CFG_TRACK_GAIN,
    CFG_SAFETY_RADIUS,
    CFG_AVOID_LENGTH,
    CFG_TRACK_SPEED_LIMIT,
    CFG_AVOID_SPEED_LIMIT,
    CFG_TOTAL_SPEED_LIMIT
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] target_east;
    logic signed [15:0] target_north;
    logic [15:0]        track_gain;
    logic [15:0]        safety_radius;
    logic [14:0]        avoid_length;
    logic [14:0]        track_speed_limit;
    logic [14:0]        avoid_speed_limit;
    logic [14:0]        total_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } trig_t;

  // clamped body velocity and heading rotation, handed to the rotate stages
  typedef struct packed {
    logic               valid;
    logic               avoiding;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] cos_h;
    logic signed [15:0] sin_h;
  } body_vel_t;

  // quarter-wave sine, Q1.14, one entry per degree
  localparam logic [14:0] QSINE [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
    15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
    15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
    15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
    15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
    15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
    15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  // d in 0..359
  function automatic trig_t sin_deg(input logic [8:0] d);
    trig_t      t;
    logic [8:0] k;
    if (d <= DEG_QUARTER) begin
      k = d;
      t.neg = 1'b0;
    end else if (d <= DEG_HALF) begin
      k = DEG_HALF - d;
      t.neg = 1'b0;
    end else if (d <= DEG_THREEQ) begin
      k = d - DEG_HALF;
      t.neg = 1'b1;
    end else begin
      k = DEG_TURN - d;
      t.neg = 1'b1;
    end
    t.mag = QSINE[k[6:0]];
    return t;
  endfunction

  function automatic trig_t cos_deg(input logic [8:0] d);
    logic [9:0] s;
    logic [9:0] w;
    s = {1'b0, d} + {1'b0, DEG_QUARTER};
    w = (s >= {1'b0, DEG_TURN}) ? s - {1'b0, DEG_TURN} : s;
    return sin_deg(w[8:0]);
  endfunction

  function automatic logic [14:0] clamp_mag(input logic [33:0] m, input logic [14:0] lim);
    return (m > {19'd0, lim}) ? lim : m[14:0];
  endfunction

  function automatic logic signed [15:0] apply_sign(input logic neg, input logic [14:0] mag);
    logic [15:0] m16;
    m16 = {1'b0, mag};
    return neg ? (16'd0 - m16) : m16;
  endfunction

endpackage

// ===== hw/rtl/track_and_avoid_velocity.sv =====
// channel  dir  word                                                    handshake
// in_      in   pos_x, pos_y, obstacle_range, obstacle_bearing, heading  tvalid/tready
// out_     out  vel_east, vel_north in tdata, avoiding in tuser         tvalid/tready
// cfg_     in   register index and data, written on cfg_wr_en           none
//
// one word per cycle sustained while out_ is not stalled, registered through the stages below
// stages: error/angles, gain mult/sine table, track clamp/avoid mult,
// avoid clamp/sum clamp, rotate mult, round/saturate into the output register
// reset (rst_n low, synchronous) empties the pipeline and loads register defaults
// a stall on out_ freezes every stage, so in_tready follows the output register
module track_and_avoid_velocity
  import tav_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[15:0], pos_y[31:16], obstacle_range[47:32], obstacle_bearing[56:48],
  // heading[72:57], zero pad
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vel_east[15:0], vel_north[31:16]
  output logic [31:0] out_tdata,
  // avoiding[0]
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t               cfg_r;
  logic               en;
  body_vel_t          body;
  logic signed [15:0] vel_east;
  logic signed [15:0] vel_north;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_east       <= 16'sd768;
      cfg_r.target_north      <= 16'sd768;
      cfg_r.track_gain        <= 16'd2048;
      cfg_r.safety_radius     <= 16'd512;
      cfg_r.avoid_length      <= 15'd512;
      cfg_r.track_speed_limit <= 15'd128;
      cfg_r.avoid_speed_limit <= 15'd128;
      cfg_r.total_speed_limit <= 15'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET_EAST:       cfg_r.target_east       <= cfg_wdata;
        CFG_TARGET_NORTH:      cfg_r.target_north      <= cfg_wdata;
        CFG_TRACK_GAIN:        cfg_r.track_gain        <= cfg_wdata;
        CFG_SAFETY_RADIUS:     cfg_r.safety_radius     <= cfg_wdata;
        CFG_AVOID_LENGTH:      cfg_r.avoid_length      <= cfg_wdata[14:0];
        CFG_TRACK_SPEED_LIMIT: cfg_r.track_speed_limit <= cfg_wdata[14:0];
        CFG_AVOID_SPEED_LIMIT: cfg_r.avoid_speed_limit <= cfg_wdata[14:0];
        CFG_TOTAL_SPEED_LIMIT: cfg_r.total_speed_limit <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  tav_track_avoid u_track_avoid (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_tvalid),
    .pos_x            (in_tdata[15:0]),
    .pos_y            (in_tdata[31:16]),
    .obstacle_range   (in_tdata[47:32]),
    .obstacle_bearing (in_tdata[56:48]),
    .heading          (in_tdata[72:57]),
    .cfg              (cfg_r),
    .body             (body)
  );

  tav_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .body      (body),
    .out_valid (out_tvalid),
    .vel_east  (vel_east),
    .vel_north (vel_north),
    .avoiding  (out_tuser)
  );

  assign out_tdata = {vel_north, vel_east};

`ifndef ASSERT_OFF
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    body.valid |-> (body.cos_h <= 16'sd16384 && body.cos_h >= -16'sd16384 &&
                    body.sin_h <= 16'sd16384 && body.sin_h >= -16'sd16384))
    else $error("heading sine or cosine out of range");

  a_body_sym: assert property (@(posedge clk) disable iff (!rst_n)
    body.valid |-> (body.bx != 16'sh8000 && body.by != 16'sh8000))
    else $error("body velocity clamp not symmetric");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(body))
    else $error("pipeline moved during output stall");
`endif

endmodule

// ===== hw/rtl/tav_track_avoid.sv =====
module tav_track_avoid
  import tav_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] obstacle_range,
  input  logic [8:0]  obstacle_bearing,
  input  logic [15:0] heading,
  input  cfg_t        cfg,
  output body_vel_t   body
);

  // stage 1: errors, avoid decision, angles
  logic                s1_valid_r;
  logic                s1_avoid_r;
  logic signed [16:0]  s1_err_x_r;
  logic signed [16:0]  s1_err_y_r;
  logic [8:0]          s1_adeg_r;
  logic [8:0]          s1_hdeg_r;

  logic signed [16:0]  err_x_nxt;
  logic signed [16:0]  err_y_nxt;
  logic                avoid_nxt;
  logic [8:0]          bear_red;
  logic [9:0]          a_sum;
  logic [8:0]          adeg_nxt;
  logic [24:0]         h_scaled;
  logic [8:0]          h_raw;
  logic [8:0]          hdeg_nxt;

  always_comb begin
    err_x_nxt = $signed({cfg.target_east[15], cfg.target_east}) - $signed({pos_x[15], pos_x});
    err_y_nxt = $signed({cfg.target_north[15], cfg.target_north}) - $signed({pos_y[15], pos_y});
    avoid_nxt = obstacle_range < cfg.safety_radius;
    bear_red  = (obstacle_bearing >= DEG_TURN) ? obstacle_bearing - DEG_TURN : obstacle_bearing;
    a_sum     = {1'b0, bear_red} + {1'b0, AVOID_OFFSET_DEG};
    adeg_nxt  = (a_sum >= {1'b0, DEG_TURN}) ? 9'(a_sum - {1'b0, DEG_TURN}) : a_sum[8:0];
    h_scaled  = 25'(heading) * 25'd360 + 25'd32768;
    h_raw     = h_scaled[24:16];
    hdeg_nxt  = (h_raw == DEG_TURN) ? 9'd0 : h_raw;
  end

  // stage 2: gain products, table lookups
  logic                s2_valid_r;
  logic                s2_avoid_r;
  logic signed [33:0]  s2_prod_x_r;
  logic signed [33:0]  s2_prod_y_r;
  trig_t               s2_ca_r;
  trig_t               s2_sa_r;
  trig_t               s2_ch_r;
  trig_t               s2_sh_r;

  // stage 3: tracking velocity, avoidance products
  logic                s3_valid_r;
  logic                s3_avoid_r;
  logic signed [15:0]  s3_tx_r;
  logic signed [15:0]  s3_ty_r;
  logic                s3_ax_neg_r;
  logic                s3_ay_neg_r;
  logic [29:0]         s3_ax_mag_r;
  logic [29:0]         s3_ay_mag_r;
  logic signed [15:0]  s3_ch_r;
  logic signed [15:0]  s3_sh_r;

  logic [33:0]         mag_x;
  logic [33:0]         mag_y;
  logic [33:0]         rnd_x;
  logic [33:0]         rnd_y;
  logic signed [15:0]  tx_nxt;
  logic signed [15:0]  ty_nxt;

  always_comb begin
    mag_x  = s2_prod_x_r[33] ? (34'd0 - s2_prod_x_r) : s2_prod_x_r;
    mag_y  = s2_prod_y_r[33] ? (34'd0 - s2_prod_y_r) : s2_prod_y_r;
    rnd_x  = (mag_x + 34'(1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
    rnd_y  = (mag_y + 34'(1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
    tx_nxt = apply_sign(s2_prod_x_r[33], clamp_mag(rnd_x, cfg.track_speed_limit));
    ty_nxt = apply_sign(s2_prod_y_r[33], clamp_mag(rnd_y, cfg.track_speed_limit));
  end

  // stage 4: avoidance velocity, summed clamp
  logic [30:0]         arnd_x;
  logic [30:0]         arnd_y;
  logic signed [15:0]  ax_nxt;
  logic signed [15:0]  ay_nxt;
  logic signed [16:0]  sum_x;
  logic signed [16:0]  sum_y;
  logic signed [16:0]  lim_hi;
  logic signed [16:0]  lim_lo;
  logic signed [16:0]  bx_full;
  logic signed [16:0]  by_full;
  body_vel_t           body_r;
  body_vel_t           body_nxt;

  always_comb begin
    arnd_x = ({1'b0, s3_ax_mag_r} + 31'(1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    arnd_y = ({1'b0, s3_ay_mag_r} + 31'(1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    ax_nxt = s3_avoid_r ? apply_sign(s3_ax_neg_r, clamp_mag(34'(arnd_x), cfg.avoid_speed_limit))
                        : 16'sd0;
    ay_nxt = s3_avoid_r ? apply_sign(s3_ay_neg_r, clamp_mag(34'(arnd_y), cfg.avoid_speed_limit))
                        : 16'sd0;
    sum_x  = $signed({s3_tx_r[15], s3_tx_r}) + $signed({ax_nxt[15], ax_nxt});
    sum_y  = $signed({s3_ty_r[15], s3_ty_r}) + $signed({ay_nxt[15], ay_nxt});
    lim_hi = $signed({2'b00, cfg.total_speed_limit});
    lim_lo = -lim_hi;
    if (sum_x > lim_hi) begin
      bx_full = lim_hi;
    end else if (sum_x < lim_lo) begin
      bx_full = lim_lo;
    end else begin
      bx_full = sum_x;
    end
    if (sum_y > lim_hi) begin
      by_full = lim_hi;
    end else if (sum_y < lim_lo) begin
      by_full = lim_lo;
    end else begin
      by_full = sum_y;
    end
    body_nxt.valid    = s3_valid_r;
    body_nxt.avoiding = s3_avoid_r;
    body_nxt.bx       = bx_full[15:0];
    body_nxt.by       = by_full[15:0];
    body_nxt.cos_h    = s3_ch_r;
    body_nxt.sin_h    = s3_sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      body_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r   <= in_valid;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      body_r.valid <= body_nxt.valid;
    end
    if (en) begin
      s1_avoid_r  <= avoid_nxt;
      s1_err_x_r  <= err_x_nxt;
      s1_err_y_r  <= err_y_nxt;
      s1_adeg_r   <= adeg_nxt;
      s1_hdeg_r   <= hdeg_nxt;

      s2_avoid_r  <= s1_avoid_r;
      s2_prod_x_r <= s1_err_x_r * $signed({1'b0, cfg.track_gain});
      s2_prod_y_r <= s1_err_y_r * $signed({1'b0, cfg.track_gain});
      s2_ca_r     <= cos_deg(s1_adeg_r);
      s2_sa_r     <= sin_deg(s1_adeg_r);
      s2_ch_r     <= cos_deg(s1_hdeg_r);
      s2_sh_r     <= sin_deg(s1_hdeg_r);

      s3_avoid_r  <= s2_avoid_r;
      s3_tx_r     <= tx_nxt;
      s3_ty_r     <= ty_nxt;
      s3_ax_neg_r <= s2_ca_r.neg;
      s3_ay_neg_r <= s2_sa_r.neg;
      s3_ax_mag_r <= cfg.avoid_length * s2_ca_r.mag;
      s3_ay_mag_r <= cfg.avoid_length * s2_sa_r.mag;
      s3_ch_r     <= apply_sign(s2_ch_r.neg, s2_ch_r.mag);
      s3_sh_r     <= apply_sign(s2_sh_r.neg, s2_sh_r.mag);

      body_r.avoiding <= body_nxt.avoiding;
      body_r.bx       <= body_nxt.bx;
      body_r.by       <= body_nxt.by;
      body_r.cos_h    <= body_nxt.cos_h;
      body_r.sin_h    <= body_nxt.sin_h;
    end
  end

  assign body = body_r;

endmodule

// ===== hw/rtl/tav_rotate.sv =====
module tav_rotate
  import tav_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  body_vel_t          body,
  output logic               out_valid,
  output logic signed [15:0] vel_east,
  output logic signed [15:0] vel_north,
  output logic               avoiding
);

  function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] r;
    logic [15:0] res;
    mag = v[32] ? (33'd0 - v) : v;
    r   = (mag + 33'(1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    if (!v[32]) begin
      res = (r > 33'd32767) ? 16'h7fff : r[15:0];
    end else begin
      res = (r > 33'd32768) ? 16'h8000 : (16'd0 - r[15:0]);
    end
    return res;
  endfunction

  // stage 5: rotation products
  logic               s5_valid_r;
  logic               s5_avoid_r;
  logic signed [31:0] s5_xc_r;
  logic signed [31:0] s5_ys_r;
  logic signed [31:0] s5_xs_r;
  logic signed [31:0] s5_yc_r;

  // stage 6: output register
  logic               out_valid_r;
  logic               avoiding_r;
  logic signed [15:0] vel_east_r;
  logic signed [15:0] vel_north_r;

  logic signed [32:0] east_sum_nxt;
  logic signed [32:0] north_sum_nxt;

  always_comb begin
    east_sum_nxt  = $signed({s5_xc_r[31], s5_xc_r}) - $signed({s5_ys_r[31], s5_ys_r});
    north_sum_nxt = $signed({s5_xs_r[31], s5_xs_r}) + $signed({s5_yc_r[31], s5_yc_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r  <= body.valid;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_avoid_r  <= body.avoiding;
      s5_xc_r     <= body.bx * body.cos_h;
      s5_ys_r     <= body.by * body.sin_h;
      s5_xs_r     <= body.bx * body.sin_h;
      s5_yc_r     <= body.by * body.cos_h;
      avoiding_r  <= s5_avoid_r;
      vel_east_r  <= round_sat(east_sum_nxt);
      vel_north_r <= round_sat(north_sum_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign vel_east  = vel_east_r;
  assign vel_north = vel_north_r;
  assign avoiding  = avoiding_r;

endmodule
